[sv/dism_pkg.sv]
// ----------------------------------------------------------------------------
// dism_pkg - shared types and constants for the disk idle spindown monitor
// Slot count, field widths, register indexes, event codes, FSM states and the
// structs passed between the top level and the sequencer.
// ----------------------------------------------------------------------------
package dism_pkg;

	localparam int DISK_SLOTS = 4;
	localparam int SLOT_W     = (DISK_SLOTS > 1) ? $clog2(DISK_SLOTS) : 1;
	localparam int TIME_W     = 32;
	localparam int CNT_W      = 32;
	localparam int EV_W       = 3;

	// config port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 32;
	localparam logic [CFG_IDX_W-1:0] REG_SKEW  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_NAMED = CFG_IDX_W'(1);
	localparam int                   REG_IDLE0 = 2;

	localparam logic [TIME_W-1:0] SKEW_RST = TIME_W'(180);
	localparam logic [TIME_W-1:0] IDLE_RST = TIME_W'(600);

	// stream payload widths
	localparam int IN_BITS    = SLOT_W + 2 * CNT_W + TIME_W;
	localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS   = SLOT_W + 2 * TIME_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [EV_W-1:0] {
		EV_NONE  = 3'd0,
		EV_START = 3'd1,
		EV_DOWN  = 3'd2,
		EV_UP    = 3'd3,
		EV_RESET = 3'd4,
		EV_REMON = 3'd5
	} event_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SKEW,
		ST_SCAN,
		ST_REMON,
		ST_SAMPLE,
		ST_IDLECHK,
		ST_RUN,
		ST_STOP,
		ST_NONE
	} state_t;

	typedef struct packed {
		logic [TIME_W-1:0]                  skew;
		logic [DISK_SLOTS-1:0]              named;
		logic [DISK_SLOTS-1:0][TIME_W-1:0]  idle;
	} cfg_t;

	typedef struct packed {
		logic              cmd;
		logic [SLOT_W-1:0] slot;
		logic [CNT_W-1:0]  rd;
		logic [CNT_W-1:0]  wr;
		logic [TIME_W-1:0] now;
	} item_t;

	typedef struct packed {
		event_t            ev;
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] run;
		logic [TIME_W-1:0] stop;
		logic              last;
	} result_t;

endpackage

[sv/dism_alu.sv]
// ----------------------------------------------------------------------------
// dism_alu - shared time subtract and compare unit
// diff = a - b modulo 2^32, compared against a limit (greater, greater-equal).
// ----------------------------------------------------------------------------
module dism_alu (
	input  logic [dism_pkg::TIME_W-1:0] a,
	input  logic [dism_pkg::TIME_W-1:0] b,
	input  logic [dism_pkg::TIME_W-1:0] lim,
	output logic [dism_pkg::TIME_W-1:0] diff,
	output logic                        gt,
	output logic                        ge
);

	assign diff = a - b;
	assign gt   = (diff > lim);
	assign ge   = (diff >= lim);

endmodule

[sv/dism_seq.sv]
// ----------------------------------------------------------------------------
// dism_seq - sequencer and per-slot state
// Walks one transaction through a few steps, sharing one subtract/compare
// unit, and hands events one at a time to the output register.
// ----------------------------------------------------------------------------
module dism_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  dism_pkg::item_t              in_item,
	input  dism_pkg::cfg_t               cfg,
	output logic                         emit_valid,
	input  logic                         emit_ok,
	output dism_pkg::result_t            emit
);

	localparam int NS = dism_pkg::DISK_SLOTS;
	localparam int SW = dism_pkg::SLOT_W;
	localparam int TW = dism_pkg::TIME_W;
	localparam int CW = dism_pkg::CNT_W;

	dism_pkg::state_t state_q, state_d;

	logic [SW-1:0] slot_q;
	logic [CW-1:0] rd_q;
	logic [CW-1:0] wr_q;
	logic [TW-1:0] now_q;
	logic [SW-1:0] idx_q;
	logic [TW-1:0] prev_time_q;
	logic [TW-1:0] diff_q;

	logic [NS-1:0] seen_q;
	logic [NS-1:0] stopped_q;
	logic [CW-1:0] prev_rd_q   [NS];
	logic [CW-1:0] prev_wr_q   [NS];
	logic [TW-1:0] last_act_q  [NS];
	logic [TW-1:0] spinup_q    [NS];
	logic [TW-1:0] spindown_q  [NS];

	logic [SW-1:0] addr;
	logic          hit;
	logic          same;
	logic          slot_ok;
	logic          accept;

	logic [TW-1:0] alu_a, alu_b, alu_lim, alu_diff;
	logic          alu_gt, alu_ge;

	// control strobes
	logic wr_first, wr_reset, wr_down, wr_active, wr_up;
	logic ld_diff, ld_prev, scan_step;

	dism_alu u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.lim  (alu_lim),
		.diff (alu_diff),
		.gt   (alu_gt),
		.ge   (alu_ge)
	);

	assign accept  = in_valid && in_ready;
	assign addr    = (state_q == dism_pkg::ST_SCAN) ? idx_q : slot_q;
	assign hit     = cfg.named[addr] && seen_q[addr];
	assign same    = (prev_rd_q[addr] == rd_q) && (prev_wr_q[addr] == wr_q);
	assign slot_ok = ({1'b0, in_item.slot} < (SW+1)'(NS));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dism_pkg::ST_IDLE: begin
				if (accept) begin
					if (!in_item.cmd) state_d = dism_pkg::ST_SKEW;
					else if (slot_ok) state_d = dism_pkg::ST_SAMPLE;
					else              state_d = dism_pkg::ST_NONE;
				end
			end
			dism_pkg::ST_SKEW: begin
				state_d = alu_gt ? dism_pkg::ST_SCAN : dism_pkg::ST_NONE;
			end
			dism_pkg::ST_SCAN: begin
				if (scan_step && idx_q == SW'(NS - 1)) state_d = dism_pkg::ST_REMON;
			end
			dism_pkg::ST_SAMPLE: begin
				if (!seen_q[addr]) begin
					if (emit_ok) state_d = dism_pkg::ST_IDLE;
				end else if (same) begin
					if (!stopped_q[addr] && cfg.idle[addr] != '0)
						state_d = dism_pkg::ST_IDLECHK;
					else
						state_d = dism_pkg::ST_NONE;
				end else begin
					state_d = stopped_q[addr] ? dism_pkg::ST_RUN : dism_pkg::ST_NONE;
				end
			end
			dism_pkg::ST_IDLECHK: begin
				if (!alu_ge)      state_d = dism_pkg::ST_NONE;
				else if (emit_ok) state_d = dism_pkg::ST_IDLE;
			end
			dism_pkg::ST_RUN: begin
				state_d = dism_pkg::ST_STOP;
			end
			dism_pkg::ST_REMON, dism_pkg::ST_STOP, dism_pkg::ST_NONE: begin
				if (emit_ok) state_d = dism_pkg::ST_IDLE;
			end
			default: begin
				state_d = dism_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs and strobes
	always_comb begin
		in_ready   = 1'b0;
		emit_valid = 1'b0;
		emit       = '0;
		alu_a      = now_q;
		alu_b      = '0;
		alu_lim    = '0;
		wr_first   = 1'b0;
		wr_reset   = 1'b0;
		wr_down    = 1'b0;
		wr_active  = 1'b0;
		wr_up      = 1'b0;
		ld_diff    = 1'b0;
		ld_prev    = 1'b0;
		scan_step  = 1'b0;
		case (state_q)
			dism_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				ld_prev  = in_valid && in_item.cmd;
			end
			dism_pkg::ST_SKEW: begin
				alu_b   = prev_time_q;
				alu_lim = cfg.skew;
				ld_prev = 1'b1;
			end
			dism_pkg::ST_SCAN: begin
				if (hit) begin
					emit_valid = 1'b1;
					emit.ev    = dism_pkg::EV_RESET;
					emit.slot  = idx_q;
					wr_reset   = emit_ok;
				end
				scan_step = !hit || emit_ok;
			end
			dism_pkg::ST_REMON: begin
				emit_valid = 1'b1;
				emit.ev    = dism_pkg::EV_REMON;
				emit.last  = 1'b1;
			end
			dism_pkg::ST_SAMPLE: begin
				if (!seen_q[addr]) begin
					emit_valid = 1'b1;
					emit.ev    = dism_pkg::EV_START;
					emit.slot  = slot_q;
					emit.last  = 1'b1;
					wr_first   = emit_ok;
				end else if (!same && !stopped_q[addr]) begin
					wr_active = 1'b1;
				end
			end
			dism_pkg::ST_IDLECHK: begin
				alu_b   = last_act_q[addr];
				alu_lim = cfg.idle[addr];
				if (alu_ge) begin
					emit_valid = 1'b1;
					emit.ev    = dism_pkg::EV_DOWN;
					emit.slot  = slot_q;
					emit.last  = 1'b1;
					wr_down    = emit_ok;
				end
			end
			dism_pkg::ST_RUN: begin
				alu_a   = spindown_q[addr];
				alu_b   = spinup_q[addr];
				ld_diff = 1'b1;
			end
			dism_pkg::ST_STOP: begin
				alu_b      = spindown_q[addr];
				emit_valid = 1'b1;
				emit.ev    = dism_pkg::EV_UP;
				emit.slot  = slot_q;
				emit.run   = diff_q;
				emit.stop  = alu_diff;
				emit.last  = 1'b1;
				wr_up      = emit_ok;
				wr_active  = emit_ok;
			end
			dism_pkg::ST_NONE: begin
				emit_valid = 1'b1;
				emit.ev    = dism_pkg::EV_NONE;
				emit.last  = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dism_pkg::ST_IDLE;
			prev_time_q <= '0;
			seen_q      <= '0;
			stopped_q   <= '0;
			idx_q       <= '0;
		end else begin
			state_q <= state_d;
			if (ld_prev) prev_time_q <= accept ? in_item.now : now_q;
			if (state_q == dism_pkg::ST_SKEW) idx_q <= '0;
			else if (scan_step)               idx_q <= idx_q + SW'(1);
			if (wr_first) seen_q[addr] <= 1'b1;
			if (wr_first || wr_reset || wr_active) stopped_q[addr] <= 1'b0;
			else if (wr_down)                      stopped_q[addr] <= 1'b1;
		end
	end

	// spindown time has a defined reset value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++) spindown_q[i] <= '0;
		end else begin
			if (wr_first)     spindown_q[addr] <= '0;
			else if (wr_down) spindown_q[addr] <= now_q;
		end
	end

	// payload: item fields, diff, per-slot stores with no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q <= in_item.slot;
			rd_q   <= in_item.rd;
			wr_q   <= in_item.wr;
			now_q  <= in_item.now;
		end
		if (ld_diff) diff_q <= alu_diff;
		if (wr_first || wr_active) begin
			prev_rd_q[addr] <= rd_q;
			prev_wr_q[addr] <= wr_q;
		end
		if (wr_first || wr_active || wr_reset) last_act_q[addr] <= now_q;
		if (wr_first || wr_reset || wr_up)     spinup_q[addr]   <= now_q;
	end

	// a final event always returns the sequencer to idle
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		emit_valid && emit_ok && emit.last |=> state_q == dism_pkg::ST_IDLE)
		else $error("sequencer not idle after final event");

	// a slot never becomes unseen
	a_seen_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		##1 ((seen_q & $past(seen_q)) == $past(seen_q)))
		else $error("slot seen bit cleared");

	// only a seen slot can be spun down
	a_stopped_seen: assert property (@(posedge clk) disable iff (!arst_n)
		(stopped_q & ~seen_q) == '0)
		else $error("stopped slot not seen");

	// no event while the input side is open
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !emit_valid)
		else $error("event emitted while idle");

endmodule

[sv/disk_idle_spindown_monitor_top.sv]
// ----------------------------------------------------------------------------
// disk_idle_spindown_monitor_top - per-slot disk idle / spindown monitor
// Input: one transaction at a time; s_tready is high only while the sequencer
//   is idle, so the next item waits until the last event of the current one
//   is loaded into the output register, which an output stall holds back. The
//   sequencer walks each item through the single shared subtract/compare unit.
// Reset: arst_n clears config to defaults, slot seen/stopped flags, spindown
//   times and previous time; counters and times fill on first sample, no sweep.
// ----------------------------------------------------------------------------
module disk_idle_spindown_monitor_top (
	input  logic                                clk,
	input  logic                                arst_n,
	// config write port
	input  logic                                cfg_we,
	input  logic [dism_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dism_pkg::CFG_W-1:0]          cfg_wdata,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// disk_slot, read_count, write_count, now_seconds, zero pad
	input  logic [dism_pkg::IN_DATA_W-1:0]      s_tdata,
	// cmd
	input  logic                                s_tuser,
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// event_slot, running_seconds, stopped_seconds, zero pad
	output logic [dism_pkg::OUT_DATA_W-1:0]     m_tdata,
	// event_res
	output logic [dism_pkg::EV_W-1:0]           m_tuser,
	// last_of_run
	output logic                                m_tlast
);

	localparam int NS = dism_pkg::DISK_SLOTS;
	localparam int SW = dism_pkg::SLOT_W;
	localparam int TW = dism_pkg::TIME_W;
	localparam int CW = dism_pkg::CNT_W;

	dism_pkg::cfg_t    cfg_q;
	dism_pkg::item_t   item;
	dism_pkg::result_t emit;
	dism_pkg::result_t res_q;
	logic              emit_valid;
	logic              emit_ok;
	logic              m_valid_q;

	// Configuration registers. Writes must land only while the block is idle, so no
	// shadowing is needed; the block does not enforce this. Indexes past the idle-time block are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.skew  <= dism_pkg::SKEW_RST;
			cfg_q.named <= '0;
			for (int i = 0; i < NS; i++) cfg_q.idle[i] <= dism_pkg::IDLE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				dism_pkg::REG_SKEW:  cfg_q.skew  <= cfg_wdata[TW-1:0];
				dism_pkg::REG_NAMED: cfg_q.named <= cfg_wdata[NS-1:0];
				default: begin
					for (int i = 0; i < NS; i++) begin
						if (cfg_index == dism_pkg::CFG_IDX_W'(dism_pkg::REG_IDLE0 + i))
							cfg_q.idle[i] <= cfg_wdata[TW-1:0];
					end
				end
			endcase
		end
	end

	// Unpack the input transaction: slot in the low bits, then counters, time.
	always_comb begin
		item.cmd  = s_tuser;
		item.slot = s_tdata[SW-1:0];
		item.rd   = s_tdata[SW +: CW];
		item.wr   = s_tdata[SW+CW +: CW];
		item.now  = s_tdata[SW+2*CW +: TW];
	end

	// Sequencer: holds all per-slot state and the shared arithmetic unit.
	dism_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_item    (item),
		.cfg        (cfg_q),
		.emit_valid (emit_valid),
		.emit_ok    (emit_ok),
		.emit       (emit)
	);

	// Output register. A new event loads when the register is empty or its
	// current content is taken in the same cycle; otherwise the sequencer
	// holds in its emitting step.
	assign emit_ok = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit_ok) begin
			m_valid_q <= emit_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_ok && emit_valid) res_q <= emit;
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = res_q.ev;
	assign m_tlast  = res_q.last;
	assign m_tdata  = dism_pkg::OUT_DATA_W'({res_q.stop, res_q.run, res_q.slot});

endmodule

[sim/tb_disk_idle_spindown_monitor_top.sv]
// ----------------------------------------------------------------------------
// tb_disk_idle_spindown_monitor_top - self-checking bench for the idle monitor
// Drives scan-start and counter-sample transactions into the block, predicts
// every event with an in-bench model of the slot timers and checks each result
// transaction in order. A directed table comes first, then random phases with
// new register settings and different sender/receiver idling patterns.
// ----------------------------------------------------------------------------
module tb_disk_idle_spindown_monitor_top;
	import dism_pkg::*;

	localparam logic CMD_SCAN   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	localparam int CLK_HALF        = 10;
	localparam int RST_CYCLES      = 8;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 36;
	// resume scan is the slowest path, as it steps through every slot; plus margin
	localparam int TAIL_CYCLES     = DISK_SLOTS + 12;
	localparam int LIMIT_CYCLES    = 400000;

	// idling pattern per phase (percent of cycles): none, sender, receiver, both
	localparam int SEND_PCT [4] = '{0, 58, 0, 34};
	localparam int RECV_PCT [4] = '{0, 0, 58, 34};

	typedef enum bit {ROW_ITEM, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t              kind;
		item_t                  it;
		bit                     typed;   // hand-written expectation replaces prediction
		result_t                want;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_W-1:0]       val;
	} stim_row_t;

	// ------------------------------------------------------------------------
	// DUT connections; every input starts at a known value
	// ------------------------------------------------------------------------
	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]       cfg_wdata = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata   = '0;   // disk_slot, read_count, write_count, now_seconds
	logic                   s_tuser   = 1'b0; // cmd
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0]  m_tdata;          // event_slot, running_seconds, stopped_seconds
	logic [EV_W-1:0]        m_tuser;          // event_res
	logic                   m_tlast;          // last_of_run

	// ------------------------------------------------------------------------
	// Predictor state: bench copy of the per-slot timers and the registers
	// ------------------------------------------------------------------------
	logic [TIME_W-1:0]      skew_cfg;
	logic [DISK_SLOTS-1:0]  named_cfg;
	logic [TIME_W-1:0]      idle_cfg     [DISK_SLOTS];
	logic                   seen         [DISK_SLOTS];
	logic                   stopped      [DISK_SLOTS];
	logic [CNT_W-1:0]       rd_hist      [DISK_SLOTS];
	logic [CNT_W-1:0]       wr_hist      [DISK_SLOTS];
	logic [TIME_W-1:0]      act_time     [DISK_SLOTS];
	logic [TIME_W-1:0]      up_time      [DISK_SLOTS];
	logic [TIME_W-1:0]      down_time    [DISK_SLOTS];
	logic [TIME_W-1:0]      last_item_time;

	result_t                item_events [$];   // events of the item just accepted
	result_t                pending_events [$]; // expected, oldest first
	stim_row_t              dir_rows [$];

	int                     send_pct = 0;
	int                     recv_pct = 0;
	int                     err_count = 0;
	int                     in_count = 0;
	int                     out_count = 0;
	int                     ev_count [8];
	result_t                got_evt;
	result_t                want_evt;

	disk_idle_spindown_monitor_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#(LIMIT_CYCLES * 2 * CLK_HALF);
		$display("TB_ERROR");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------
	function automatic void predictor_reset();
		skew_cfg       = SKEW_RST;
		named_cfg      = '0;
		last_item_time = '0;
		for (int i = 0; i < DISK_SLOTS; i++) begin
			idle_cfg[i]  = IDLE_RST;
			seen[i]      = 1'b0;
			stopped[i]   = 1'b0;
			rd_hist[i]   = '0;
			wr_hist[i]   = '0;
			act_time[i]  = '0;
			up_time[i]   = '0;
			down_time[i] = '0;
		end
		foreach (ev_count[i]) ev_count[i] = 0;
	endfunction

	function automatic void add_event(event_t ev, logic [SLOT_W-1:0] sl,
			logic [TIME_W-1:0] run, logic [TIME_W-1:0] stop);
		result_t r;
		r.ev   = ev;
		r.slot = sl;
		r.run  = run;
		r.stop = stop;
		r.last = 1'b0;
		item_events.push_back(r);
	endfunction

	// Events caused by one accepted item; all time deltas wrap at 32 bits
	function automatic void predict_disk_events(input item_t it);
		logic [TIME_W-1:0] gap;
		int                s;
		item_events.delete();
		s = it.slot;
		if (it.cmd == CMD_SCAN) begin
			gap = it.now - last_item_time;
			// resume from suspend: reset named slots that were seen, in slot order
			if (gap > skew_cfg) begin
				for (int i = 0; i < DISK_SLOTS; i++)
					if (named_cfg[i] && seen[i]) begin
						up_time[i]  = it.now;
						act_time[i] = it.now;
						stopped[i]  = 1'b0;
						add_event(EV_RESET, SLOT_W'(i), '0, '0);
					end
				add_event(EV_REMON, '0, '0, '0);
			end
		end else if (s < DISK_SLOTS) begin
			if (!seen[s]) begin
				seen[s]      = 1'b1;
				rd_hist[s]   = it.rd;
				wr_hist[s]   = it.wr;
				act_time[s]  = it.now;
				up_time[s]   = it.now;
				down_time[s] = '0;
				stopped[s]   = 1'b0;
				add_event(EV_START, it.slot, '0, '0);
			end else if (rd_hist[s] == it.rd && wr_hist[s] == it.wr) begin
				gap = it.now - act_time[s];
				if (!stopped[s] && idle_cfg[s] != '0 && gap >= idle_cfg[s]) begin
					down_time[s] = it.now;
					stopped[s]   = 1'b1;
					add_event(EV_DOWN, it.slot, '0, '0);
				end
			end else begin
				if (stopped[s]) begin
					add_event(EV_UP, it.slot, down_time[s] - up_time[s],
						it.now - down_time[s]);
					up_time[s] = it.now;
				end
				rd_hist[s]  = it.rd;
				wr_hist[s]  = it.wr;
				act_time[s] = it.now;
				stopped[s]  = 1'b0;
			end
		end
		last_item_time = it.now;
		if (item_events.size() == 0)
			add_event(EV_NONE, '0, '0, '0);
		item_events[item_events.size() - 1].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------------
	// Directed table helpers
	// ------------------------------------------------------------------------
	function automatic void row_item(logic cmd, logic [SLOT_W-1:0] sl, logic [CNT_W-1:0] rd,
			logic [CNT_W-1:0] wr, logic [TIME_W-1:0] now);
		stim_row_t r;
		r.kind    = ROW_ITEM;
		r.it.cmd  = cmd;
		r.it.slot = sl;
		r.it.rd   = rd;
		r.it.wr   = wr;
		r.it.now  = now;
		r.typed   = 1'b0;
		r.want    = '0;
		r.idx     = '0;
		r.val     = '0;
		dir_rows.push_back(r);
	endfunction

	// Attach a single hand-written result to the last item row
	function automatic void row_want(event_t ev, logic [SLOT_W-1:0] sl,
			logic [TIME_W-1:0] run, logic [TIME_W-1:0] stop);
		int n;
		n = dir_rows.size() - 1;
		dir_rows[n].typed     = 1'b1;
		dir_rows[n].want.ev   = ev;
		dir_rows[n].want.slot = sl;
		dir_rows[n].want.run  = run;
		dir_rows[n].want.stop = stop;
		dir_rows[n].want.last = 1'b1;
	endfunction

	function automatic void row_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		stim_row_t r;
		r.kind  = ROW_REG;
		r.it    = '0;
		r.typed = 1'b0;
		r.want  = '0;
		r.idx   = idx;
		r.val   = val;
		dir_rows.push_back(r);
	endfunction

	// ------------------------------------------------------------------------
	// Random items: mostly well-formed samples that advance time plausibly,
	// some scans with small and large gaps, a few fully random items
	// ------------------------------------------------------------------------
	function automatic item_t make_random_item();
		item_t it;
		int    r;
		int    s;
		r       = $urandom_range(0, 99);
		it.slot = $urandom_range(0, DISK_SLOTS - 1);
		s       = it.slot;
		it.rd   = $urandom;
		it.wr   = $urandom;
		if (r < 8) begin
			it.cmd = $urandom_range(0, 1);
			it.now = $urandom;
		end else if (r < 22) begin
			it.cmd = CMD_SCAN;
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: it.now = last_item_time + $urandom_range(0, 200);
				5, 6, 7, 8:    it.now = last_item_time + $urandom_range(200, 1500);
				default:       it.now = $urandom;
			endcase
		end else begin
			it.cmd = CMD_SAMPLE;
			it.rd  = rd_hist[s];
			it.wr  = wr_hist[s];
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: ;   // idle disk
				5, 6:          it.rd = rd_hist[s] + $urandom_range(1, 40);
				7:             it.wr = wr_hist[s] + $urandom_range(1, 40);
				default: begin
					it.rd = rd_hist[s] + $urandom_range(1, 40);
					it.wr = wr_hist[s] + $urandom_range(1, 40);
				end
			endcase
			if ($urandom_range(0, 9) == 0)
				it.now = last_item_time + $urandom_range(300, 2000);
			else
				it.now = last_item_time + $urandom_range(0, 250);
		end
		return it;
	endfunction

	// ------------------------------------------------------------------------
	// Driver tasks; all are entered and left right after a rising edge
	// ------------------------------------------------------------------------
	task automatic push_item(input item_t it, input bit typed, input result_t want);
		if (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_DATA_W'({it.now, it.wr, it.rd, it.slot});
		s_tuser  <= it.cmd;
		// handshake decided from settled values mid-cycle
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		in_count++;
		predict_disk_events(it);
		if (typed)
			pending_events.push_back(want);
		else
			foreach (item_events[i]) pending_events.push_back(item_events[i]);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_events.size() != 0);
	endtask

	task automatic config_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_SKEW:  skew_cfg  = val;
			REG_NAMED: named_cfg = val[DISK_SLOTS-1:0];
			default:   idle_cfg[idx - REG_IDLE0] = val;
		endcase
	endtask

	// ------------------------------------------------------------------------
	// Receiver: stall pattern follows the current phase
	// ------------------------------------------------------------------------
	always @(posedge clk)
		m_tready <= (recv_pct == 0) || ($urandom_range(0, 99) >= recv_pct);

	// ------------------------------------------------------------------------
	// Result checker: a transaction is decided from values settled mid-cycle,
	// it completes on the following rising edge
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_evt.ev   = event_t'(m_tuser);
			got_evt.slot = m_tdata[SLOT_W-1:0];
			got_evt.run  = m_tdata[SLOT_W +: TIME_W];
			got_evt.stop = m_tdata[SLOT_W + TIME_W +: TIME_W];
			got_evt.last = m_tlast;
			out_count++;
			ev_count[m_tuser]++;
			if (pending_events.size() == 0) begin
				err_count++;
				$error("result transaction with nothing expected: event_res %0d slot %0d",
					m_tuser, got_evt.slot);
			end else begin
				want_evt = pending_events.pop_front();
				if (got_evt.ev !== want_evt.ev) begin
					err_count++;
					$error("event_res: expected %0d, got %0d", want_evt.ev, m_tuser);
				end
				if (got_evt.slot !== want_evt.slot) begin
					err_count++;
					$error("event_slot: expected %0d, got %0d", want_evt.slot, got_evt.slot);
				end
				if (got_evt.run !== want_evt.run) begin
					err_count++;
					$error("running_seconds: expected %0d, got %0d", want_evt.run, got_evt.run);
				end
				if (got_evt.stop !== want_evt.stop) begin
					err_count++;
					$error("stopped_seconds: expected %0d, got %0d",
						want_evt.stop, got_evt.stop);
				end
				if (got_evt.last !== want_evt.last) begin
					err_count++;
					$error("last_of_run: expected %0d, got %0d", want_evt.last, got_evt.last);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		logic [TIME_W-1:0] idle_val;
		int                mode;

		predictor_reset();

		// slot 0: start, just short of idle, spin-down, stays down, spin-up
		row_item(CMD_SAMPLE, 0, 0, 0, 100);           row_want(EV_START, 0, 0, 0);
		row_item(CMD_SAMPLE, 0, 0, 0, 699);           row_want(EV_NONE, 0, 0, 0);
		row_item(CMD_SAMPLE, 0, 0, 0, 700);           row_want(EV_DOWN, 0, 0, 0);
		row_item(CMD_SAMPLE, 0, 0, 0, 800);           row_want(EV_NONE, 0, 0, 0);
		row_item(CMD_SAMPLE, 0, 1, 0, 900);           row_want(EV_UP, 0, 600, 200);
		// scan gaps below, at and just past the reset skew, nothing named
		row_item(CMD_SCAN, 0, 0, 0, 1000);            row_want(EV_NONE, 0, 0, 0);
		row_item(CMD_SCAN, 0, 0, 0, 1180);            row_want(EV_NONE, 0, 0, 0);
		row_item(CMD_SCAN, 3, '1, '1, 1361);          row_want(EV_REMON, 0, 0, 0);
		// slot 3: all-ones fields, idle interval spans the time wrap
		row_item(CMD_SAMPLE, 3, '1, '1, '1);          row_want(EV_START, 3, 0, 0);
		row_item(CMD_SAMPLE, 3, '1, '1, 599);         row_want(EV_DOWN, 3, 0, 0);
		// resume with every slot named: slots 1 and 2 unseen, so skipped
		row_reg(REG_NAMED, 32'hF);
		row_item(CMD_SCAN, 0, 0, 0, 32'h8000_0000);
		row_item(CMD_SAMPLE, 3, 0, 0, 32'h8000_0010);
		// idle time zero never spins down
		row_reg(CFG_IDX_W'(REG_IDLE0 + 1), '0);
		row_item(CMD_SAMPLE, 1, 32'hAAAA_AAAA, 32'h5555_5555, 5);
		row_want(EV_START, 1, 0, 0);
		row_item(CMD_SAMPLE, 1, 32'hAAAA_AAAA, 32'h5555_5555, '1);
		row_want(EV_NONE, 0, 0, 0);
		// largest skew: full-range gap is not a resume
		row_reg(REG_SKEW, '1);
		row_item(CMD_SCAN, 0, 0, 0, 32'hFFFF_FFFE);   row_want(EV_NONE, 0, 0, 0);
		// smallest skew: resume across the wrap, slot 2 still unseen
		row_reg(REG_SKEW, 1);
		row_item(CMD_SCAN, 0, 0, 0, 1);
		// largest idle time, reached only by a full wrap; running time wraps too
		row_reg(CFG_IDX_W'(REG_IDLE0 + 2), '1);
		row_item(CMD_SAMPLE, 2, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678);
		row_want(EV_START, 2, 0, 0);
		row_item(CMD_SAMPLE, 2, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5677);
		row_want(EV_DOWN, 2, 0, 0);
		row_item(CMD_SAMPLE, 2, 32'h5555_5556, 32'hAAAA_AAAA, 32'h1234_5680);

		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed part, reset register values until the first register row
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_REG) begin
				wait_drained();
				config_write(dir_rows[i].idx, dir_rows[i].val);
			end else begin
				push_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
			end
		end

		// random phases: new registers while idle, then a burst of items
		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			mode     = p % 4;
			send_pct = SEND_PCT[mode];
			recv_pct = RECV_PCT[mode];
			case (p)
				0:       config_write(REG_SKEW, 1);
				1:       config_write(REG_SKEW, '1);
				default: config_write(REG_SKEW, $urandom_range(2, 800));
			endcase
			case (p)
				0:       config_write(REG_NAMED, 32'hF);
				1:       config_write(REG_NAMED, '0);
				default: config_write(REG_NAMED, $urandom_range(0, 15));
			endcase
			for (int s = 0; s < DISK_SLOTS; s++) begin
				case (p)
					1:       idle_val = '0;
					2:       idle_val = 1;
					4:       idle_val = '1;
					default: idle_val = $urandom_range(20, 600);
				endcase
				config_write(CFG_IDX_W'(REG_IDLE0 + s), idle_val);
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// now and then hold the sender until the block has emptied
				if (n == ITEMS_PER_PHASE / 2 && p % 3 == 1)
					wait_drained();
				push_item(make_random_item(), 1'b0, '0);
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d input and %0d result transactions over %0d register phases.",
			in_count, out_count, PHASES + 1);
		$display("Events: %0d starts, %0d spin-downs, %0d spin-ups, %0d resets, %0d remonitors.",
			ev_count[EV_START], ev_count[EV_DOWN], ev_count[EV_UP],
			ev_count[EV_RESET], ev_count[EV_REMON]);
		if (err_count == 0 && pending_events.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
